FILE: src/bbms_pkg.sv
// ----------------------------------------------------------------------------
// Box majority stencil package
// Shared widths, limits, register codes and helper functions.
// ----------------------------------------------------------------------------
package bbms_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int MAX_RADIUS = 3;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int HIST_W     = 2 * MAX_RADIUS;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CFG_COLS_W = 11;
    localparam int CFG_ROWS_W = 13;
    localparam int RAD_W      = 2;
    localparam int ROUGH_W    = 6;
    localparam int CNT_W      = $clog2(WIN_SIDE * WIN_SIDE + 1);
    localparam int HALF_W     = 5;
    localparam int CMP_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_COLS_W-1:0] COLS_RESET  = CFG_COLS_W'(66);
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET  = CFG_ROWS_W'(66);
    localparam logic [RAD_W-1:0]      RAD_RESET   = RAD_W'(1);
    localparam logic [ROUGH_W-1:0]    ROUGH_RESET = ROUGH_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PADDED_COLS = 2'd0,
        REG_PADDED_ROWS = 2'd1,
        REG_RADIUS      = 2'd2,
        REG_ROUGHNESS   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
    } t_pos;

    function automatic logic [HALF_W-1:0] half_count(input logic [RAD_W-1:0] rad);
        logic [HALF_W-1:0] r;
        r = HALF_W'(rad);
        return HALF_W'(r * (r + HALF_W'(1)) * HALF_W'(2));
    endfunction

endpackage

FILE: src/bbms_position.sv
// ----------------------------------------------------------------------------
// Box majority stencil position tracker
// Raster row and column counters with wrap, interior test and last-cell flag.
// ----------------------------------------------------------------------------
module bbms_position (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_frame_start,
    input  logic [bbms_pkg::CFG_COLS_W-1:0]  i_cols,
    input  logic [bbms_pkg::CFG_ROWS_W-1:0]  i_rows,
    input  logic [bbms_pkg::RAD_W-1:0]       i_radius,
    output logic [bbms_pkg::COL_W-1:0]       o_col_addr,
    output bbms_pkg::t_pos                   o_pos
);

    logic [bbms_pkg::COL_W-1:0]      r_col;
    logic [bbms_pkg::ROW_W-1:0]      r_row;
    logic [bbms_pkg::COL_W-1:0]      n_col;
    logic [bbms_pkg::ROW_W-1:0]      n_row;
    logic [bbms_pkg::COL_W-1:0]      col_now;
    logic [bbms_pkg::ROW_W-1:0]      row_now;
    logic [bbms_pkg::CFG_COLS_W-1:0] col_inc;
    logic [bbms_pkg::CFG_ROWS_W-1:0] row_inc;
    logic [bbms_pkg::RAD_W:0]        twice_rad;

    always_comb begin
        col_now = i_frame_start ? '0 : r_col;
        row_now = i_frame_start ? '0 : r_row;
        if ({1'b0, col_now} >= i_cols) begin
            col_now = '0;
        end
        if ({1'b0, row_now} >= i_rows) begin
            row_now = '0;
        end
        twice_rad = {i_radius, 1'b0};
        col_inc   = {1'b0, col_now} + bbms_pkg::CFG_COLS_W'(1);
        row_inc   = {1'b0, row_now} + bbms_pkg::CFG_ROWS_W'(1);
        if (col_inc >= i_cols) begin
            n_col = '0;
            n_row = (row_inc >= i_rows) ? '0 : row_inc[bbms_pkg::ROW_W-1:0];
        end else begin
            n_col = col_inc[bbms_pkg::COL_W-1:0];
            n_row = row_now;
        end
        o_col_addr = col_now;
        o_pos.row  = row_now - bbms_pkg::ROW_W'(i_radius);
        o_pos.col  = col_now - bbms_pkg::COL_W'(i_radius);
        o_pos.emit = (row_now >= bbms_pkg::ROW_W'(twice_rad))
                  && (col_now >= bbms_pkg::COL_W'(twice_rad));
        o_pos.last = ({1'b0, row_now} == i_rows - bbms_pkg::CFG_ROWS_W'(1))
                  && ({1'b0, col_now} == i_cols - bbms_pkg::CFG_COLS_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // A frame start places the word at column zero, so the next column is one or wraps.
    a_start_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_frame_start |=> r_col == bbms_pkg::COL_W'(1) || r_col == '0)
        else $error("column counter wrong after frame start");

    a_hold_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_col) && $stable(r_row))
        else $error("position moved without a word");

endmodule

FILE: src/bbms_line_buffer.sv
// ----------------------------------------------------------------------------
// Box majority stencil line buffer
// Per-column history of the previous rows with a registered read and bypass.
// ----------------------------------------------------------------------------
module bbms_line_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [bbms_pkg::COL_W-1:0]    i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [bbms_pkg::COL_W-1:0]    i_wr_addr,
    input  logic [bbms_pkg::HIST_W-1:0]   i_wr_data,
    output logic [bbms_pkg::HIST_W-1:0]   o_rd_data
);

    logic [bbms_pkg::HIST_W-1:0] mem [bbms_pkg::MAX_COLS];
    logic [bbms_pkg::HIST_W-1:0] r_q;
    logic [bbms_pkg::HIST_W-1:0] r_fwd_data;
    logic                        r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // A write to the address being read in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

FILE: src/bbms_window.sv
// ----------------------------------------------------------------------------
// Box majority stencil window
// Sliding square window of column words, wall count and hysteresis decision.
// ----------------------------------------------------------------------------
module bbms_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  logic [bbms_pkg::WIN_SIDE-1:0]   i_column,
    input  logic [bbms_pkg::RAD_W-1:0]      i_radius,
    input  logic [bbms_pkg::ROUGH_W-1:0]    i_roughness,
    output logic                            o_new_cell
);

    logic [bbms_pkg::WIN_SIDE-1:0] r_window [bbms_pkg::WIN_SIDE];
    logic [bbms_pkg::RAD_W:0]      side;
    logic [bbms_pkg::RAD_W:0]      centre_idx;
    logic [bbms_pkg::CNT_W-1:0]    count;
    logic [bbms_pkg::CNT_W-1:0]    walls;
    logic                          centre;
    logic [bbms_pkg::CMP_W-1:0]    half;
    logic [bbms_pkg::CMP_W-1:0]    rough;
    logic [bbms_pkg::CMP_W-1:0]    walls_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bbms_pkg::WIN_SIDE; i++) begin
                r_window[i] <= '0;
            end
        end else if (i_shift) begin
            for (int i = bbms_pkg::WIN_SIDE - 1; i > 0; i--) begin
                r_window[i] <= r_window[i-1];
            end
            r_window[0] <= i_column;
        end
    end

    always_comb begin
        side       = {i_radius, 1'b1};
        centre_idx = {1'b0, i_radius};
        count      = '0;
        for (int dx = 0; dx < bbms_pkg::WIN_SIDE; dx++) begin
            for (int dy = 0; dy < bbms_pkg::WIN_SIDE; dy++) begin
                if (dx < int'(side) && dy < int'(side)) begin
                    count = count + bbms_pkg::CNT_W'(r_window[dx][dy]);
                end
            end
        end
        centre    = r_window[centre_idx][centre_idx];
        walls     = count - bbms_pkg::CNT_W'(centre);
        half      = bbms_pkg::CMP_W'(bbms_pkg::half_count(i_radius));
        rough     = bbms_pkg::CMP_W'(i_roughness);
        walls_ext = bbms_pkg::CMP_W'(walls);
        priority if (walls_ext >= half + rough) begin
            o_new_cell = 1'b1;
        end else if (walls_ext + rough <= half) begin
            o_new_cell = 1'b0;
        end else begin
            o_new_cell = centre;
        end
    end

endmodule

FILE: src/binary_box_majority_stencil_core.sv
// ----------------------------------------------------------------------------
// Binary box majority stencil core
// One cave-generation step over a padded grid streamed in raster order.
// ----------------------------------------------------------------------------
// The core takes one cell word per clock unless stalled and emits one result
// word per interior cell through the stage-one registers, the window and the
// output register; border cells give no word. Throughput is one word per
// cycle unless stalled, set by the line buffer of 1024 columns by six rows,
// which has one read port and one write port and is read and written once
// per cell. The output register holds a result while the downstream side
// stalls, and the input is stalled only while that register is full and stalled.
module binary_box_majority_stencil_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_cell_value,
    input  logic                             i_frame_start,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_new_cell,
    output logic [bbms_pkg::ROW_W-1:0]       o_out_row,
    output logic [bbms_pkg::COL_W-1:0]       o_out_col,
    output logic                             o_frame_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bbms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bbms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [bbms_pkg::CFG_COLS_W-1:0] r_cols;
    logic [bbms_pkg::CFG_ROWS_W-1:0] r_rows;
    logic [bbms_pkg::RAD_W-1:0]      r_radius;
    logic [bbms_pkg::ROUGH_W-1:0]    r_rough;
    logic [bbms_pkg::CFG_COLS_W-1:0] cols_eff;
    logic [bbms_pkg::CFG_ROWS_W-1:0] rows_eff;

    logic                            en;
    logic                            accept;
    logic [bbms_pkg::COL_W-1:0]      col_addr;
    bbms_pkg::t_pos                  pos_now;

    logic                            r_s1_valid;
    logic                            r_s1_cell;
    logic [bbms_pkg::COL_W-1:0]      r_s1_addr;
    bbms_pkg::t_pos                  r_s1_pos;
    logic [bbms_pkg::HIST_W-1:0]     hist;
    logic [bbms_pkg::WIN_SIDE-1:0]   colword;

    logic                            r_s2_valid;
    bbms_pkg::t_pos                  r_s2_pos;
    logic                            new_cell;

    logic                            r_o_valid;
    logic                            r_o_new;
    logic [bbms_pkg::ROW_W-1:0]      r_o_row;
    logic [bbms_pkg::COL_W-1:0]      r_o_col;
    logic                            r_o_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= bbms_pkg::COLS_RESET;
            r_rows   <= bbms_pkg::ROWS_RESET;
            r_radius <= bbms_pkg::RAD_RESET;
            r_rough  <= bbms_pkg::ROUGH_RESET;
        end else if (i_cfg_valid) begin
            unique case (bbms_pkg::t_cfg_reg'(i_cfg_index))
                bbms_pkg::REG_PADDED_COLS: begin
                    r_cols <= i_cfg_data[bbms_pkg::CFG_COLS_W-1:0];
                end
                bbms_pkg::REG_PADDED_ROWS: begin
                    r_rows <= i_cfg_data[bbms_pkg::CFG_ROWS_W-1:0];
                end
                bbms_pkg::REG_RADIUS: begin
                    r_radius <= i_cfg_data[bbms_pkg::RAD_W-1:0];
                end
                bbms_pkg::REG_ROUGHNESS: begin
                    r_rough <= i_cfg_data[bbms_pkg::ROUGH_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        cols_eff = r_cols;
        if (r_cols == '0) begin
            cols_eff = bbms_pkg::CFG_COLS_W'(1);
        end else if (r_cols > bbms_pkg::CFG_COLS_W'(bbms_pkg::MAX_COLS)) begin
            cols_eff = bbms_pkg::CFG_COLS_W'(bbms_pkg::MAX_COLS);
        end
        rows_eff = r_rows;
        if (r_rows == '0) begin
            rows_eff = bbms_pkg::CFG_ROWS_W'(1);
        end else if (r_rows > bbms_pkg::CFG_ROWS_W'(bbms_pkg::MAX_ROWS)) begin
            rows_eff = bbms_pkg::CFG_ROWS_W'(bbms_pkg::MAX_ROWS);
        end
    end

    assign en      = !(r_o_valid && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;

    bbms_position u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_frame_start),
        .i_cols        (cols_eff),
        .i_rows        (rows_eff),
        .i_radius      (r_radius),
        .o_col_addr    (col_addr),
        .o_pos         (pos_now)
    );

    bbms_line_buffer u_line_buffer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (col_addr),
        .i_wr_en   (en && r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (colword[bbms_pkg::HIST_W-1:0]),
        .o_rd_data (hist)
    );

    assign colword = {hist, r_s1_cell};

    bbms_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (en && r_s1_valid),
        .i_column    (colword),
        .i_radius    (r_radius),
        .i_roughness (r_rough),
        .o_new_cell  (new_cell)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid && r_s2_pos.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (accept) begin
                r_s1_cell <= i_cell_value;
                r_s1_addr <= col_addr;
                r_s1_pos  <= pos_now;
            end
            if (r_s1_valid) begin
                r_s2_pos <= r_s1_pos;
            end
            if (r_s2_valid) begin
                r_o_new  <= new_cell;
                r_o_row  <= r_s2_pos.row;
                r_o_col  <= r_s2_pos.col;
                r_o_last <= r_s2_pos.last;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_new_cell  = r_o_new;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_frame_end = r_o_last;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while the output register is free");

    a_s2_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && !r_s1_valid |=> !r_s2_valid)
        else $error("window stage filled without a line buffer word");

endmodule
